// ----- hw/rtl/npbrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npbrs_pkg
// Shared types and constants for the nine-patch border run scanner.
// ----------------------------------------------------------------------------
package npbrs_pkg;

    localparam int MAX_EDGE_DEF = 4096;   // default longest inner edge
    localparam int PIX_W        = 32;     // pixel word
    localparam int FIELD_W      = 13;     // range_begin / range_stop
    localparam int CFG_W        = 8;      // widest config register
    localparam int CFG_IDX_W    = 2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_VALUE = 2'd2;

    localparam logic [1:0] SELECT_BYTE_RST = 2'd3;
    localparam logic [7:0] TEST_MASK_RST   = 8'hFF;
    localparam logic [7:0] MATCH_VALUE_RST = 8'hFF;

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_LEFT   = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_RIGHT  = 2'd3
    } edge_sel_t;

    typedef struct packed {
        logic [1:0]         edge_tag;
        logic               range_valid;
        logic [FIELD_W-1:0] range_begin;
        logic [FIELD_W-1:0] range_stop;
        logic               edge_done;
    } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/npbrs_pixel_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npbrs_pixel_if
// Border pixel channel: valid/ready plus one pixel item.
// ----------------------------------------------------------------------------
interface npbrs_pixel_if import npbrs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_word;
    logic [1:0]       edge_sel;
    logic             edge_last;

    modport source (output valid, pixel_word, edge_sel, edge_last, input ready);
    modport sink   (input valid, pixel_word, edge_sel, edge_last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/npbrs_result_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npbrs_result_if
// Result channel: valid/ready plus one range item.
// ----------------------------------------------------------------------------
interface npbrs_result_if import npbrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         edge_tag;
    logic               range_valid;
    logic [FIELD_W-1:0] range_begin;
    logic [FIELD_W-1:0] range_stop;
    logic               edge_done;

    modport source (output valid, edge_tag, range_valid, range_begin, range_stop,
                    edge_done, input ready);
    modport sink   (input valid, edge_tag, range_valid, range_begin, range_stop,
                    edge_done, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/npbrs_skid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npbrs_skid
// Two-entry output buffer: result register plus one skid slot.
// ----------------------------------------------------------------------------
module npbrs_skid import npbrs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    input  wire result_t push_item,
    output logic         push_ready,
    output logic         pop_valid,
    output result_t      pop_item,
    input  wire logic    pop_ready
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_item   = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop_ready)
        begin
            // skid slot drains first; no push can arrive while it is full
            main_valid_next = skid_valid_reg || push_valid;
            main_next       = skid_valid_reg ? skid_reg : push_item;
            skid_valid_next = 1'b0;
        end
        else if (push_valid && push_ready)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // skid slot only fills behind a stalled result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot full with empty result register");

    // a taken result is replaced by the skid entry
    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved up");

    // a stalled result holds still
    a_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && !pop_ready) |=> (pop_valid && $stable(pop_item)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- hw/rtl/nine_patch_border_run_scan_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nine_patch_border_run_scan_core
// Run scanner over the inner border pixels of a nine-patch image.
// ----------------------------------------------------------------------------
// Takes one border pixel per cycle, tagged with its edge and an end-of-edge
// flag. A pixel is a marker when its selected byte ANDed with test_mask
// equals match_value. Top and left edges report every run of markers as a
// stretch range [begin, stop); an edge without runs reports [0, length), and
// an edge whose runs were all reported already ends with an end marker
// (range_valid 0). Bottom and right edges report only at their last pixel:
// child origin (first run start + 1) and size (run length), or 1 and 0 with
// no run. Rate: one item per cycle while pix.ready is high. The marker test
// and run bookkeeping sit between the state registers and the result
// register, so a result is registered before it shows on res. A two-entry
// output buffer lets one result wait on an output stall with pix.ready high;
// pix.ready drops only once two results are waiting. Pixels past MAX_EDGE on
// one edge are not tested and the edge length is taken as MAX_EDGE. Config
// writes belong in idle time; writes to an unused index are ignored.
// ----------------------------------------------------------------------------
module nine_patch_border_run_scan_core import npbrs_pkg::*;
#(
    parameter int MAX_EDGE = MAX_EDGE_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    npbrs_pixel_if.sink               pix,
    npbrs_result_if.source            res,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    // position must hold MAX_EDGE itself (saturated edge)
    localparam int POS_W = (MAX_EDGE < 2) ? 1 : $clog2(MAX_EDGE + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_EDGE);

    // config registers
    logic [1:0] select_byte_reg;
    logic [7:0] test_mask_reg;
    logic [7:0] match_value_reg;

    // edge scan state
    logic [POS_W-1:0] pixel_pos_reg,     pixel_pos_next;
    logic             run_open_reg,      run_open_next;
    logic [POS_W-1:0] run_first_reg,     run_first_next;
    logic             any_run_seen_reg,  any_run_seen_next;
    logic [POS_W-1:0] content_start_reg, content_start_next;
    logic [POS_W-1:0] content_end_reg,   content_end_next;

    logic             accept;
    logic             stretch_edge;
    logic             in_range;
    logic [POS_W-1:0] edge_len;
    logic [7:0]       test_byte;
    logic             marker;
    logic             run_closed;
    logic             produce;
    result_t          result;
    logic             push_ready;

    assign accept = pix.valid && pix.ready;
    assign pix.ready = push_ready;

    // ------------------------------------------------------------------
    // config writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_byte_reg <= SELECT_BYTE_RST;
            test_mask_reg   <= TEST_MASK_RST;
            match_value_reg <= MATCH_VALUE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SELECT_BYTE: select_byte_reg <= cfg_wdata[1:0];
                CFG_TEST_MASK:   test_mask_reg   <= cfg_wdata;
                CFG_MATCH_VALUE: match_value_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // marker test
    // ------------------------------------------------------------------
    assign test_byte = pix.pixel_word[{select_byte_reg, 3'b000} +: 8];
    assign marker    = (test_byte & test_mask_reg) == match_value_reg;
    assign in_range  = pixel_pos_reg < POS_MAX;
    // pos + 1 never wraps: pos < MAX_EDGE here
    assign edge_len  = in_range ? (pixel_pos_reg + POS_W'(1)) : POS_MAX;

    always_comb
    begin
        stretch_edge = edge_sel_t'(pix.edge_sel) inside {EDGE_TOP, EDGE_LEFT};
    end

    // ------------------------------------------------------------------
    // run bookkeeping and result
    // ------------------------------------------------------------------
    always_comb
    begin
        pixel_pos_next     = pixel_pos_reg;
        run_open_next      = run_open_reg;
        run_first_next     = run_first_reg;
        any_run_seen_next  = any_run_seen_reg;
        content_start_next = content_start_reg;
        content_end_next   = content_end_reg;
        run_closed         = 1'b0;

        if (in_range)
        begin
            if (stretch_edge)
            begin
                if (marker && !run_open_reg)
                begin
                    run_open_next     = 1'b1;
                    run_first_next    = pixel_pos_reg;
                    any_run_seen_next = 1'b1;
                end
                else if (!marker && run_open_reg)
                begin
                    run_closed    = 1'b1;
                    run_open_next = 1'b0;
                end
            end
            else if (!any_run_seen_reg)
            begin
                // bottom/right: capture the first run only
                if (marker && !run_open_reg)
                begin
                    run_open_next  = 1'b1;
                    run_first_next = pixel_pos_reg;
                end
                else if (!marker && run_open_reg)
                begin
                    content_start_next = run_first_reg;
                    content_end_next   = pixel_pos_reg;
                    any_run_seen_next  = 1'b1;
                    run_open_next      = 1'b0;
                end
            end
            pixel_pos_next = pixel_pos_reg + POS_W'(1);
        end

        result.edge_tag    = pix.edge_sel;
        result.range_valid = 1'b1;
        result.range_begin = '0;
        result.range_stop  = '0;
        result.edge_done   = pix.edge_last;

        if (stretch_edge)
        begin
            produce = run_closed || pix.edge_last;
            if (run_closed)
            begin
                result.range_begin = FIELD_W'(run_first_reg);
                result.range_stop  = FIELD_W'(pixel_pos_reg);
            end
            else if (run_open_next)
            begin
                result.range_begin = FIELD_W'(run_first_next);
                result.range_stop  = FIELD_W'(edge_len);
            end
            else if (!any_run_seen_next)
            begin
                result.range_stop = FIELD_W'(edge_len);
            end
            else
            begin
                result.range_valid = 1'b0;   // end marker
            end
        end
        else
        begin
            produce = pix.edge_last;
            if (any_run_seen_next)
            begin
                result.range_begin = FIELD_W'(content_start_next) + FIELD_W'(1);
                result.range_stop  = FIELD_W'(content_end_next)
                                   - FIELD_W'(content_start_next);
            end
            else if (run_open_next)
            begin
                result.range_begin = FIELD_W'(run_first_next) + FIELD_W'(1);
                result.range_stop  = FIELD_W'(edge_len) - FIELD_W'(run_first_next);
            end
            else
            begin
                result.range_begin = FIELD_W'(1);
            end
        end

        // edge end: start the next edge from scratch
        if (pix.edge_last)
        begin
            pixel_pos_next     = '0;
            run_open_next      = 1'b0;
            run_first_next     = '0;
            any_run_seen_next  = 1'b0;
            content_start_next = '0;
            content_end_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_pos_reg     <= '0;
            run_open_reg      <= 1'b0;
            run_first_reg     <= '0;
            any_run_seen_reg  <= 1'b0;
            content_start_reg <= '0;
            content_end_reg   <= '0;
        end
        else if (accept)
        begin
            pixel_pos_reg     <= pixel_pos_next;
            run_open_reg      <= run_open_next;
            run_first_reg     <= run_first_next;
            any_run_seen_reg  <= any_run_seen_next;
            content_start_reg <= content_start_next;
            content_end_reg   <= content_end_next;
        end
    end

    // ------------------------------------------------------------------
    // output buffer
    // ------------------------------------------------------------------
    result_t out_item;

    npbrs_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (accept && produce),
        .push_item  (result),
        .push_ready (push_ready),
        .pop_valid  (res.valid),
        .pop_item   (out_item),
        .pop_ready  (res.ready)
    );

    assign res.edge_tag    = out_item.edge_tag;
    assign res.range_valid = out_item.range_valid;
    assign res.range_begin = out_item.range_begin;
    assign res.range_stop  = out_item.range_stop;
    assign res.edge_done   = out_item.edge_done;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_pos_reg <= POS_MAX)
        else $error("pixel position past edge limit");

    a_edge_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pix.edge_last) |=>
            (pixel_pos_reg == '0 && !run_open_reg && !any_run_seen_reg))
        else $error("edge state not cleared after last pixel");

    // a waiting result stays offered until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid)
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

// ----- dv/nine_patch_border_run_scan_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nine_patch_border_run_scan_core_tb
// Self-checking bench for the nine-patch border run scanner.
// ----------------------------------------------------------------------------
// Streams border pixels through the valid/ready pixel channel. A small
// predictor tracks the per-edge scan state and queues the range items that
// each accepted pixel should produce. Each accepted result item is checked
// field by field against the oldest queued range. The stimulus starts with
// hand-built edges. Random edges follow, with runs of marker pixels, plus
// noise that switches edges without an end flag. Match settings change
// between phases, and each change waits until the scanner has drained.
// ----------------------------------------------------------------------------

// Mirror of the scanner state; one call per accepted pixel item.
class border_range_predictor;
    logic [1:0]         sel_byte;
    logic [7:0]         test_mask;
    logic [7:0]         match_val;
    int unsigned        pixel_pos;
    bit                 run_open;
    int unsigned        run_first;
    bit                 run_seen;
    int unsigned        content_start;
    int unsigned        content_end;
    npbrs_pkg::result_t pending_ranges[$];
    int unsigned        errors;

    function new();
        sel_byte      = npbrs_pkg::SELECT_BYTE_RST;
        test_mask     = npbrs_pkg::TEST_MASK_RST;
        match_val     = npbrs_pkg::MATCH_VALUE_RST;
        pixel_pos     = 0;
        run_open      = 1'b0;
        run_first     = 0;
        run_seen      = 1'b0;
        content_start = 0;
        content_end   = 0;
        errors        = 0;
    endfunction

    function void write_reg(logic [npbrs_pkg::CFG_IDX_W-1:0] idx,
                            logic [npbrs_pkg::CFG_W-1:0] data);
        case (idx)
            npbrs_pkg::CFG_SELECT_BYTE: sel_byte  = data[1:0];
            npbrs_pkg::CFG_TEST_MASK:   test_mask = data[7:0];
            npbrs_pkg::CFG_MATCH_VALUE: match_val = data[7:0];
            default: ;
        endcase
    endfunction

    function void push_range(logic [1:0] side, bit valid, int unsigned b,
                             int unsigned e, bit done);
        npbrs_pkg::result_t r;
        r.edge_tag    = side;
        r.range_valid = valid;
        r.range_begin = b[npbrs_pkg::FIELD_W-1:0];
        r.range_stop  = e[npbrs_pkg::FIELD_W-1:0];
        r.edge_done   = done;
        pending_ranges.push_back(r);
    endfunction

    function void take_pixel(logic [31:0] word, logic [1:0] side, bit last);
        bit          stretch;
        bit          hit;
        bit          closed;
        int unsigned len;
        int unsigned close_b;
        int unsigned close_e;
        logic [7:0]  b;

        stretch = (side == npbrs_pkg::EDGE_TOP) || (side == npbrs_pkg::EDGE_LEFT);
        closed  = 1'b0;
        close_b = 0;
        close_e = 0;
        len     = (pixel_pos < npbrs_pkg::MAX_EDGE_DEF) ? pixel_pos + 1
                                                        : npbrs_pkg::MAX_EDGE_DEF;
        // pixels past the edge limit are not tested
        if (pixel_pos < npbrs_pkg::MAX_EDGE_DEF) begin
            b   = word[8*sel_byte +: 8];
            hit = (b & test_mask) == match_val;
            if (stretch) begin
                if (hit && !run_open) begin
                    run_open  = 1'b1;
                    run_first = pixel_pos;
                    run_seen  = 1'b1;
                end else if (!hit && run_open) begin
                    closed   = 1'b1;
                    close_b  = run_first;
                    close_e  = pixel_pos;
                    run_open = 1'b0;
                end
            end else if (!run_seen) begin
                if (hit && !run_open) begin
                    run_open  = 1'b1;
                    run_first = pixel_pos;
                end else if (!hit && run_open) begin
                    content_start = run_first;
                    content_end   = pixel_pos;
                    run_seen      = 1'b1;
                    run_open      = 1'b0;
                end
            end
            pixel_pos++;
        end

        if (stretch) begin
            if (closed)
                push_range(side, 1'b1, close_b, close_e, last);
            else if (last) begin
                if (run_open)
                    push_range(side, 1'b1, run_first, len, 1'b1);
                else if (!run_seen)
                    push_range(side, 1'b1, 0, len, 1'b1);
                else
                    push_range(side, 1'b0, 0, 0, 1'b1);
            end
        end else if (last) begin
            if (run_seen)
                push_range(side, 1'b1, content_start + 1, content_end - content_start,
                           1'b1);
            else if (run_open)
                push_range(side, 1'b1, run_first + 1, len - run_first, 1'b1);
            else
                push_range(side, 1'b1, 1, 0, 1'b1);
        end

        if (last) begin
            pixel_pos     = 0;
            run_open      = 1'b0;
            run_first     = 0;
            run_seen      = 1'b0;
            content_start = 0;
            content_end   = 0;
        end
    endfunction

    function void check_range(npbrs_pkg::result_t got);
        npbrs_pkg::result_t want;

        if (pending_ranges.size() == 0) begin
            $error("unexpected result item: edge_tag %0d range_valid %0d begin %0d stop %0d",
                   got.edge_tag, got.range_valid, got.range_begin, got.range_stop);
            errors++;
            return;
        end
        want = pending_ranges.pop_front();
        if (got.edge_tag !== want.edge_tag) begin
            $error("edge_tag: expected %0d, got %0d", want.edge_tag, got.edge_tag);
            errors++;
        end
        if (got.range_valid !== want.range_valid) begin
            $error("range_valid: expected %0d, got %0d", want.range_valid,
                   got.range_valid);
            errors++;
        end
        if (got.range_begin !== want.range_begin) begin
            $error("range_begin: expected %0d, got %0d", want.range_begin,
                   got.range_begin);
            errors++;
        end
        if (got.range_stop !== want.range_stop) begin
            $error("range_stop: expected %0d, got %0d", want.range_stop, got.range_stop);
            errors++;
        end
        if (got.edge_done !== want.edge_done) begin
            $error("edge_done: expected %0d, got %0d", want.edge_done, got.edge_done);
            errors++;
        end
    endfunction
endclass

module nine_patch_border_run_scan_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npbrs_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 12;
    localparam int WATCHDOG_LIMIT    = 2000;
    // a result is registered before it shows on res; the settle time covers that
    localparam int SETTLE_CYCLES     = 4;
    localparam int DRAIN_CYCLES      = 8;
    localparam int ITEMS_PER_SETTING = 135;

    // index with no register behind it; the scanner ignores it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    npbrs_pixel_if  pix ();
    npbrs_result_if res ();

    border_range_predictor ranges;

    int unsigned items_sent         = 0;
    int unsigned quiet_cycles       = 0;
    int          sender_idle_pct    = 11;
    int          receiver_stall_pct = 54;

    nine_patch_border_run_scan_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Result side: ready is redrawn every cycle from the current stall rate.
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Both channels are sampled at the clock edge, before any driver update.
    // Pixel items feed the predictor, result items are checked against it.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pix.valid && pix.ready)
                ranges.take_pixel(pix.pixel_word, pix.edge_sel, pix.edge_last);
            if (res.valid && res.ready)
                ranges.check_range({res.edge_tag, res.range_valid, res.range_begin,
                                    res.range_stop, res.edge_done});
            if ((pix.valid && pix.ready) || (res.valid && res.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Hang detector: too many cycles without any handshake ends the run.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Random pixel word whose selected byte is forced to hit or miss the
    // current match setting. A miss cannot be forced when mask and match are
    // both zero; a hit cannot be forced when match has bits outside the mask.
    function automatic logic [31:0] make_word(bit hit);
        logic [31:0] word;
        logic [7:0]  b;
        int          tries;

        word = $urandom;
        b    = word[8*ranges.sel_byte +: 8];
        if (hit)
            b = (b & ~ranges.test_mask) | ranges.match_val;
        else
            for (tries = 0; tries < 16 && ((b & ranges.test_mask) == ranges.match_val);
                 tries++)
                b = 8'($urandom);
        word[8*ranges.sel_byte +: 8] = b;
        return word;
    endfunction

    // Presents one pixel item, with random leading idle cycles. Returns at the
    // edge where the item is taken; valid stays up for the next caller.
    task automatic send_pixel(logic [31:0] word, edge_sel_t side, bit last);
        while ($urandom_range(99) < sender_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel_word <= word;
        pix.edge_sel   <= side;
        pix.edge_last  <= last;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Well-formed edge: marker/non-marker runs from a two-state walk, end
    // flag on the final pixel only.
    task automatic send_edge(edge_sel_t side, int len, int stay_pct);
        bit hit;
        int i;

        hit = 1'($urandom_range(1));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) >= stay_pct)
                hit = !hit;
            send_pixel(make_word(hit), side, i == len - 1);
        end
    endtask

    // Holds the sender off until every expected range has come back, then
    // lets the pipe settle for pixels that produce nothing.
    task automatic wait_idle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (ranges.pending_ranges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One write, then a cycle with the enable low.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ranges.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_setting(logic [1:0] sel, logic [7:0] mask, logic [7:0] match_v);
        write_cfg(CFG_SELECT_BYTE, CFG_W'(sel));
        write_cfg(CFG_TEST_MASK, mask);
        write_cfg(CFG_MATCH_VALUE, match_v);
    endtask

    // Mostly well-formed edges with random content; the rest is noise with
    // random edge tags and end flags, plus the odd full drain.
    task automatic run_random(int unsigned count);
        int unsigned start;
        int          pick;
        int          len;
        int          burst;
        int          i;

        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 82) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(1, 24);
                send_edge(edge_sel_t'($urandom_range(3)), len, $urandom_range(30, 90));
            end else if (pick < 97) begin
                burst = $urandom_range(1, 6);
                for (i = 0; i < burst; i++)
                    send_pixel($urandom, edge_sel_t'($urandom_range(3)),
                               $urandom_range(5) == 0);
            end else begin
                wait_idle();
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_SELECT_BYTE;
        cfg_wdata      <= '0;
        pix.valid      <= 1'b0;
        pix.pixel_word <= '0;
        pix.edge_sel   <= EDGE_TOP;
        pix.edge_last  <= 1'b0;
        ranges = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- hand-built edges, reset setting: marker = byte 3 is 0xFF ----
        // top: run closed mid-edge, then a run still open at the end
        send_pixel(32'hFFFF_FFFF, EDGE_TOP, 1'b0);
        send_pixel(32'hFF00_0000, EDGE_TOP, 1'b0);
        send_pixel(32'h0000_0000, EDGE_TOP, 1'b0);
        send_pixel(32'hFF5A_A55A, EDGE_TOP, 1'b1);
        // left without any marker: whole edge is one range
        send_pixel(32'hFEFF_FFFF, EDGE_LEFT, 1'b0);
        send_pixel(32'h7F12_3456, EDGE_LEFT, 1'b0);
        send_pixel(32'h0000_0000, EDGE_LEFT, 1'b1);
        // left: run closed by the last pixel, done rides on the closing range
        send_pixel(32'hFFFF_FFFF, EDGE_LEFT, 1'b0);
        send_pixel(32'hFEFF_FFFF, EDGE_LEFT, 1'b1);
        // top: runs all reported before the end, so only an end marker
        send_pixel(32'hFF00_0000, EDGE_TOP, 1'b0);
        send_pixel(32'h0000_0000, EDGE_TOP, 1'b0);
        send_pixel(32'h00FF_FFFF, EDGE_TOP, 1'b1);
        // bottom: first run kept, later run ignored
        send_pixel(32'h0000_0000, EDGE_BOTTOM, 1'b0);
        send_pixel(32'hFFFF_FFFF, EDGE_BOTTOM, 1'b0);
        send_pixel(32'hFF00_00FF, EDGE_BOTTOM, 1'b0);
        send_pixel(32'h8000_0000, EDGE_BOTTOM, 1'b0);
        send_pixel(32'hFFFF_FFFF, EDGE_BOTTOM, 1'b1);
        // right: run still open at the end stops at the edge length
        send_pixel(32'h0000_0000, EDGE_RIGHT, 1'b0);
        send_pixel(32'h7FFF_FFFF, EDGE_RIGHT, 1'b0);
        send_pixel(32'hFFFF_FFFF, EDGE_RIGHT, 1'b1);
        // right, single pixel, no run: origin 1, size 0
        send_pixel(32'h0000_0000, EDGE_RIGHT, 1'b1);
        // top, single marker pixel
        send_pixel(32'hFFFF_FFFF, EDGE_TOP, 1'b1);
        // edge switch with no end flag: state carries across edges
        send_pixel(32'hFFFF_FFFF, EDGE_TOP, 1'b0);
        send_pixel(32'h0000_0000, EDGE_BOTTOM, 1'b0);
        send_pixel(32'hFFFF_FFFF, EDGE_RIGHT, 1'b1);

        // ---- sender idles lightly, receiver stalls often ----
        run_random(ITEMS_PER_SETTING);
        wait_idle();
        apply_setting(2'd0, 8'h0F, 8'h05);
        run_random(ITEMS_PER_SETTING);
        wait_idle();

        // ---- roles swapped ----
        sender_idle_pct    = 54;
        receiver_stall_pct = 11;
        // zero mask and match: every pixel is a marker
        apply_setting(2'd1, 8'h00, 8'h00);
        run_random(ITEMS_PER_SETTING);
        wait_idle();
        apply_setting(2'd2, 8'h81, 8'h01);
        write_cfg(CFG_UNUSED, 8'hA5);
        run_random(ITEMS_PER_SETTING);
        wait_idle();

        // ---- no idling on either side ----
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        apply_setting(2'd0, 8'hFF, 8'h00);
        run_random(ITEMS_PER_SETTING);
        wait_idle();
        // match outside the mask: no pixel is ever a marker
        apply_setting(2'd2, 8'h00, 8'hFF);
        run_random(ITEMS_PER_SETTING);
        wait_idle();
        apply_setting(2'd1, 8'hF0, 8'hA0);
        run_random(ITEMS_PER_SETTING);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ranges.errors == 0 && ranges.pending_ranges.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/npbrs_pkg.sv
hw/rtl/npbrs_pixel_if.sv
hw/rtl/npbrs_result_if.sv
hw/rtl/npbrs_skid.sv
hw/rtl/nine_patch_border_run_scan_core.sv
dv/nine_patch_border_run_scan_core_tb.sv
